/* hw/rtl/ire_pkg.sv */
// ----------------------------------------------------------------------------
// Image rotation engine package
// Item types, configuration register indexes and default sizes shared by the
// rotation engine and its users.
// ----------------------------------------------------------------------------
package ire_pkg;

    // Default sizes of the frame store and the fixed-point format.
    localparam int DEF_MAX_SRC_WIDTH  = 1024;
    localparam int DEF_MAX_SRC_HEIGHT = 1024;
    localparam int DEF_PIXEL_BITS     = 32;
    localparam int DEF_FRAC_BITS      = 14;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_COS_Q       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIN_Q       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_WIDTH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_HEIGHT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEST_WIDTH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEST_HEIGHT = 3'd5;

    // Item operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [10:0] col;
        logic [10:0] row;
        logic [31:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic        covered;
    } t_out_item;

endpackage

/* hw/rtl/image_rotation_engine.sv */
// ----------------------------------------------------------------------------
// Image rotation engine
// Nearest-neighbor rotation by inverse mapping over a single-port frame store.
// ----------------------------------------------------------------------------
// Usage:
// Write items (operation 0) load a source pixel at (col, row) into the frame
// store; writes outside the programmed source size are dropped. Read items
// (operation 1) name a destination pixel; the engine maps it back to a source
// coordinate with the programmed cosine and sine and returns the stored pixel
// with covered set, or zero with covered clear when the coordinate falls
// outside the source or the destination pixel lies outside the destination.
// Write items produce no result item.
// Throughput is one item per cycle while the input is not stalled, writes and
// reads mixed freely, because every item makes exactly one access to the
// single frame store port. A read item passes through stages 1 to 6 and then
// into the output queue, from which its result item is offered.
// Results enter an 8-entry output queue; the input is stalled only when the
// reads in flight plus queued results would fill it, so a stall on the output
// side backs up into the input after that many reads.
// Reset clears the pipeline, the queue and the registers to their defaults;
// the frame store content is undefined until written. Configuration writes
// are always ready; the user, not the block, keeps them to an idle engine.
// ----------------------------------------------------------------------------
module image_rotation_engine #(
    parameter int MAX_SRC_WIDTH  = ire_pkg::DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = ire_pkg::DEF_MAX_SRC_HEIGHT,
    parameter int PIXEL_BITS     = ire_pkg::DEF_PIXEL_BITS,
    parameter int FRAC_BITS      = ire_pkg::DEF_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input item channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  ire_pkg::t_in_item                    i_in_item,
    // Result item channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output ire_pkg::t_out_item                   o_out_item,
    // Configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ire_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [ire_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import ire_pkg::*;

    // Offsets from the destination center span -2047..2047.
    localparam int DELTA_W = 13;
    // A Q2.14 coefficient times an offset.
    localparam int PROD_W  = 16 + DELTA_W;
    // Sum of two products plus room for the ceiling bias.
    localparam int ACC_W   = PROD_W + 2;
    // Source coordinates: the shifted sum plus the source center, and wide
    // enough to compare against the largest store size.
    localparam int CRD_W   = (ACC_W - FRAC_BITS + 1 > 14) ? ACC_W - FRAC_BITS + 1 : 14;
    localparam int COL_W   = $clog2(MAX_SRC_WIDTH);
    localparam int ROW_W   = $clog2(MAX_SRC_HEIGHT);
    localparam int DEPTH   = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam logic signed [ACC_W-1:0] CEIL_BIAS = ACC_W'((1 << FRAC_BITS) - 1);
    localparam logic signed [CRD_W-1:0] MAX_W_C   = CRD_W'(MAX_SRC_WIDTH);
    localparam logic signed [CRD_W-1:0] MAX_H_C   = CRD_W'(MAX_SRC_HEIGHT);

    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration registers
    logic signed [15:0] r_cos_q;
    logic signed [15:0] r_sin_q;
    logic [10:0]        r_src_width;
    logic [10:0]        r_src_height;
    logic [11:0]        r_dest_width;
    logic [11:0]        r_dest_height;

    // Stage 1: offsets from the destination center
    logic                     r_s1_valid;
    logic                     r_s1_read;
    logic                     r_s1_dest_ok;
    logic [10:0]              r_s1_col;
    logic [10:0]              r_s1_row;
    logic [PIXEL_BITS-1:0]    r_s1_pixel;
    logic signed [DELTA_W-1:0] r_s1_dx;
    logic signed [DELTA_W-1:0] r_s1_dy;

    // Stage 2: the four products
    logic                     r_s2_valid;
    logic                     r_s2_read;
    logic                     r_s2_dest_ok;
    logic [10:0]              r_s2_col;
    logic [10:0]              r_s2_row;
    logic [PIXEL_BITS-1:0]    r_s2_pixel;
    logic signed [PROD_W-1:0] r_s2_cdx;
    logic signed [PROD_W-1:0] r_s2_sdy;
    logic signed [PROD_W-1:0] r_s2_sdx;
    logic signed [PROD_W-1:0] r_s2_cdy;

    // Stage 3: fixed-point source coordinates
    logic                     r_s3_valid;
    logic                     r_s3_read;
    logic                     r_s3_dest_ok;
    logic [10:0]              r_s3_col;
    logic [10:0]              r_s3_row;
    logic [PIXEL_BITS-1:0]    r_s3_pixel;
    logic signed [ACC_W-1:0]  r_s3_acc_x;
    logic signed [ACC_W-1:0]  r_s3_acc_y;

    // Stage 4: integer coordinates into the store (source or mapped)
    logic                     r_s4_valid;
    logic                     r_s4_read;
    logic                     r_s4_dest_ok;
    logic [PIXEL_BITS-1:0]    r_s4_pixel;
    logic signed [CRD_W-1:0]  r_s4_x;
    logic signed [CRD_W-1:0]  r_s4_y;

    // Stage 5: store address and hit flag, memory access at its edge
    logic                     r_s5_valid;
    logic                     r_s5_read;
    logic                     r_s5_hit;
    logic [PIXEL_BITS-1:0]    r_s5_pixel;
    logic [ADDR_W-1:0]        r_s5_addr;

    // Stage 6: read data
    logic                     r_s6_valid;
    logic                     r_s6_hit;
    logic [PIXEL_BITS-1:0]    r_s6_data;

    // Frame store
    logic [PIXEL_BITS-1:0]    frame_mem [DEPTH];

    // Result queue
    t_out_item                r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0]        r_wr_ptr;
    logic [QPTR_W-1:0]        r_rd_ptr;
    logic [QCNT_W-1:0]        r_fill;
    logic [QCNT_W-1:0]        r_credit;
    logic [QCNT_W-1:0]        n_credit;

    logic                     in_accept;
    logic                     out_accept;
    logic                     cfg_write;
    logic signed [ACC_W-1:0]  ceil_x;
    logic signed [ACC_W-1:0]  ceil_y;
    logic signed [CRD_W-1:0]  eff_w;
    logic signed [CRD_W-1:0]  eff_h;
    logic                     in_bounds;
    t_out_item                push_item;

    // The input is held off only when every queue slot is claimed by a read
    // already in flight or a result still waiting.
    assign o_in_stall  = (r_credit == QCNT_W'(QUEUE_DEPTH));
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_accept  = o_out_valid && !i_out_stall;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_q       <= 16'sd16384;
            r_sin_q       <= '0;
            r_src_width   <= 11'd1024;
            r_src_height  <= 11'd1024;
            r_dest_width  <= 12'd1024;
            r_dest_height <= 12'd1024;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                CFG_COS_Q:       r_cos_q       <= i_cfg_data;
                CFG_SIN_Q:       r_sin_q       <= i_cfg_data;
                CFG_SRC_WIDTH:   r_src_width   <= i_cfg_data[10:0];
                CFG_SRC_HEIGHT:  r_src_height  <= i_cfg_data[10:0];
                CFG_DEST_WIDTH:  r_dest_width  <= i_cfg_data[11:0];
                CFG_DEST_HEIGHT: r_dest_height <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    // Sizes above the store are capped for the bounds test only; the
    // centers keep the programmed values.
    always_comb begin
        eff_w = (CRD_W'(r_src_width) < MAX_W_C) ? CRD_W'(r_src_width) : MAX_W_C;
        eff_h = (CRD_W'(r_src_height) < MAX_H_C) ? CRD_W'(r_src_height) : MAX_H_C;
    end

    // Ceiling of the Q-format sum: add one less than one unit, then shift
    // arithmetically, which is exact for both signs.
    assign ceil_x = (r_s3_acc_x + CEIL_BIAS) >>> FRAC_BITS;
    assign ceil_y = (r_s3_acc_y + CEIL_BIAS) >>> FRAC_BITS;

    assign in_bounds = (r_s4_x >= 0) && (r_s4_x < eff_w) &&
                       (r_s4_y >= 0) && (r_s4_y < eff_h);

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid && r_s5_read;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        r_s1_read    <= (i_in_item.operation == OP_READ);
        r_s1_dest_ok <= (12'(i_in_item.col) < r_dest_width) &&
                        (12'(i_in_item.row) < r_dest_height);
        r_s1_col     <= i_in_item.col;
        r_s1_row     <= i_in_item.row;
        r_s1_pixel   <= i_in_item.pixel_in[PIXEL_BITS-1:0];
        r_s1_dx      <= $signed(DELTA_W'(i_in_item.col)) -
                        $signed(DELTA_W'(r_dest_width[11:1]));
        r_s1_dy      <= $signed(DELTA_W'(i_in_item.row)) -
                        $signed(DELTA_W'(r_dest_height[11:1]));

        r_s2_read    <= r_s1_read;
        r_s2_dest_ok <= r_s1_dest_ok;
        r_s2_col     <= r_s1_col;
        r_s2_row     <= r_s1_row;
        r_s2_pixel   <= r_s1_pixel;
        r_s2_cdx     <= PROD_W'(r_cos_q) * PROD_W'(r_s1_dx);
        r_s2_sdy     <= PROD_W'(r_sin_q) * PROD_W'(r_s1_dy);
        r_s2_sdx     <= PROD_W'(r_sin_q) * PROD_W'(r_s1_dx);
        r_s2_cdy     <= PROD_W'(r_cos_q) * PROD_W'(r_s1_dy);

        r_s3_read    <= r_s2_read;
        r_s3_dest_ok <= r_s2_dest_ok;
        r_s3_col     <= r_s2_col;
        r_s3_row     <= r_s2_row;
        r_s3_pixel   <= r_s2_pixel;
        r_s3_acc_x   <= ACC_W'(r_s2_cdx) + ACC_W'(r_s2_sdy);
        r_s3_acc_y   <= ACC_W'(r_s2_cdy) - ACC_W'(r_s2_sdx);

        // Writes address the store by their own column and row; reads by
        // the mapped coordinate.
        r_s4_read    <= r_s3_read;
        r_s4_dest_ok <= r_s3_dest_ok;
        r_s4_pixel   <= r_s3_pixel;
        if (r_s3_read) begin
            r_s4_x <= CRD_W'(ceil_x) + CRD_W'(r_src_width[10:1]);
            r_s4_y <= CRD_W'(ceil_y) + CRD_W'(r_src_height[10:1]);
        end else begin
            r_s4_x <= CRD_W'(r_s3_col);
            r_s4_y <= CRD_W'(r_s3_row);
        end

        r_s5_read  <= r_s4_read;
        r_s5_hit   <= in_bounds && (!r_s4_read || r_s4_dest_ok);
        r_s5_pixel <= r_s4_pixel;
        r_s5_addr  <= ADDR_W'(ADDR_W'(r_s4_y[ROW_W-1:0]) * ADDR_W'(MAX_SRC_WIDTH)) +
                      ADDR_W'(r_s4_x[COL_W-1:0]);

        r_s6_hit   <= r_s5_hit;
    end

    // Single-port frame store. All accesses happen in item order at one
    // stage, so a read always sees every earlier write.
    always_ff @(posedge i_clk) begin
        if (r_s5_valid && r_s5_hit && !r_s5_read) begin
            frame_mem[r_s5_addr] <= r_s5_pixel;
        end
        r_s6_data <= frame_mem[r_s5_addr];
    end

    always_comb begin
        push_item.pixel_out = r_s6_hit ? 32'(r_s6_data) : '0;
        push_item.covered   = r_s6_hit;
    end

    always_ff @(posedge i_clk) begin
        if (r_s6_valid) begin
            r_queue[r_wr_ptr] <= push_item;
        end
    end

    // A credit is taken when a read is accepted and returned when its result
    // leaves, so a pushed result always finds a free queue slot.
    always_comb begin
        n_credit = r_credit;
        if (in_accept && (i_in_item.operation == OP_READ)) begin
            n_credit = n_credit + 1'b1;
        end
        if (out_accept) begin
            n_credit = n_credit - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_credit <= '0;
        end else begin
            r_credit <= n_credit;
            if (r_s6_valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (out_accept) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fill <= r_fill + QCNT_W'(r_s6_valid) - QCNT_W'(out_accept);
        end
    end

    assign o_out_valid = (r_fill != '0);
    assign o_out_item  = r_queue[r_rd_ptr];

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image rotation engine testbench
// Loads source pixels, programs a sequence of rotations and image sizes, and
// checks every destination pixel read against a nearest-neighbor inverse-
// mapping predictor kept inside the bench, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
    import ire_pkg::*;

    localparam int     MAX_W          = DEF_MAX_SRC_WIDTH;
    localparam int     MAX_H          = DEF_MAX_SRC_HEIGHT;
    localparam int     FRAC           = DEF_FRAC_BITS;
    localparam longint ROUND_UP       = (longint'(1) <<< FRAC) - 1;
    // Used by wait_idle to let the pipeline settle after the last result.
    localparam int     RESULT_LATENCY = 7;
    localparam int     WATCHDOG_LIMIT = 2000;

    // Register indexes the engine does not implement; writes must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_7 = 3'd7;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    t_in_item               in_item   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_out_item              out_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Geometry as the engine holds it, updated at each register write.
    logic signed [15:0] geo_cos   = 16'sd16384;
    logic signed [15:0] geo_sin   = 16'sd0;
    logic [10:0]        geo_src_w = 11'd1024;
    logic [10:0]        geo_src_h = 11'd1024;
    logic [11:0]        geo_dst_w = 12'd1024;
    logic [11:0]        geo_dst_h = 12'd1024;

    // Source pixels as the engine should hold them, by row * MAX_W + col.
    logic [31:0] src_pixels [int];
    // Entries that the stimulus has already arranged to write. Reads that
    // land on any other entry get a write of that entry queued ahead of them.
    bit          planned_written [int];

    t_in_item  pending_items [$];
    t_out_item expected_results [$];

    int  in_presented   = 0;
    int  in_accepted    = 0;
    int  in_gap         = 0;
    int  out_taken      = 0;
    int  out_paced      = 0;
    int  out_wait       = 0;
    int  cfg_writes     = 0;
    bit  in_no_idle     = 1'b0;
    bit  out_no_idle    = 1'b0;
    int  fail_count     = 0;
    int  n_writes       = 0;
    int  n_reads        = 0;
    int  n_covered      = 0;
    int  n_backpressure = 0;
    int  phases_run     = 0;
    int  progress_seen  = 0;
    int  idle_cycles    = 0;

    image_rotation_engine i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // True when (x, y) lies inside the source. The bounds are capped at the
    // frame store size, while the centre keeps the raw register values.
    function automatic bit in_source(input longint x, input longint y);
        longint ew;
        longint eh;
        ew = (geo_src_w < MAX_W) ? longint'(geo_src_w) : longint'(MAX_W);
        eh = (geo_src_h < MAX_H) ? longint'(geo_src_h) : longint'(MAX_H);
        return x >= 0 && y >= 0 && x < ew && y < eh;
    endfunction

    // Inverse mapping of a destination pixel. Returns 1 and the frame store
    // address when the pixel is inside the destination and lands inside the
    // source. The rounding is a ceiling on the exact fixed-point sum, done as
    // an add of one LSB short of a unit and an arithmetic shift.
    function automatic bit map_to_source(input logic [10:0] col, input logic [10:0] row,
                                         output int addr);
        longint c;
        longint s;
        longint dx;
        longint dy;
        longint sx;
        longint sy;
        addr = 0;
        if (col >= geo_dst_w || row >= geo_dst_h) return 1'b0;
        c  = longint'(geo_cos);
        s  = longint'(geo_sin);
        dx = longint'(col) - longint'(geo_dst_w >> 1);
        dy = longint'(row) - longint'(geo_dst_h >> 1);
        sx = ((c * dx + s * dy + ROUND_UP) >>> FRAC) + longint'(geo_src_w >> 1);
        sy = ((c * dy - s * dx + ROUND_UP) >>> FRAC) + longint'(geo_src_h >> 1);
        if (!in_source(sx, sy)) return 1'b0;
        addr = int'(sy) * MAX_W + int'(sx);
        return 1'b1;
    endfunction

    function automatic t_out_item rotate_lookup(input t_in_item it);
        t_out_item res;
        int        addr;
        res = '0;
        if (map_to_source(it.col, it.row, addr)) begin
            res.covered   = 1'b1;
            res.pixel_out = src_pixels.exists(addr) ? src_pixels[addr] : '0;
        end
        return res;
    endfunction

    // Queues one item, after a write where a read needs one, and returns how many items went into the queue.
    function automatic int queue_item(input logic op, input logic [10:0] col,
                                      input logic [10:0] row, input logic [31:0] pix);
        t_in_item it;
        int       addr;
        int       pushed;
        pushed = 0;
        if (op == OP_READ && map_to_source(col, row, addr) && !planned_written.exists(addr)) begin
            it.operation = OP_WRITE;
            it.col       = 11'(addr % MAX_W);
            it.row       = 11'(addr / MAX_W);
            it.pixel_in  = $urandom();
            pending_items.push_back(it);
            planned_written[addr] = 1'b1;
            pushed++;
        end
        if (op == OP_WRITE && in_source(longint'(col), longint'(row)))
            planned_written[int'(row) * MAX_W + int'(col)] = 1'b1;
        it.operation = op;
        it.col       = col;
        it.row       = row;
        it.pixel_in  = pix;
        pending_items.push_back(it);
        return pushed + 1;
    endfunction

    // Input driver: presents the next item once the previous one has been
    // accepted and its drawn gap has run out. Valid only drops in a gap or
    // when nothing is left to send, so a stalled item never changes.
    always @(negedge clk) begin
        if (rst_n && in_presented == in_accepted) begin
            if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap--;
            end else if (pending_items.size() > 0) begin
                in_item  <= pending_items.pop_front();
                in_valid <= 1'b1;
                in_presented++;
                in_gap = in_no_idle ? 0 : $urandom_range(0, 7);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result side pacing: after each accepted result, stall for a drawn
    // number of cycles. Long runs of stalls back up into the input stall.
    always @(negedge clk) begin
        if (out_taken != out_paced) begin
            out_paced = out_taken;
            out_wait  = out_no_idle ? 0 : $urandom_range(0, 7);
        end
        out_stall <= (out_wait > 0);
        if (out_wait > 0) out_wait--;
    end

    // Checker and predictor. The result is checked before the same edge's
    // input item is predicted, so a result can never match a read that was
    // only accepted at this very edge.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                out_taken++;
                if (expected_results.size() == 0) begin
                    $error("result item with no read waiting: pixel_out %h covered %b",
                           out_item.pixel_out, out_item.covered);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_item.pixel_out !== want.pixel_out) begin
                        $error("pixel_out: expected %h, got %h", want.pixel_out, out_item.pixel_out);
                        fail_count++;
                    end
                    if (out_item.covered !== want.covered) begin
                        $error("covered: expected %b, got %b", want.covered, out_item.covered);
                        fail_count++;
                    end
                    if (want.covered) n_covered++;
                end
            end
            if (in_valid && in_stall) n_backpressure++;
            if (in_valid && !in_stall) begin
                in_accepted++;
                if (in_item.operation == OP_READ) begin
                    expected_results.push_back(rotate_lookup(in_item));
                    n_reads++;
                end else begin
                    if (in_source(longint'(in_item.col), longint'(in_item.row)))
                        src_pixels[int'(in_item.row) * MAX_W + int'(in_item.col)] = in_item.pixel_in;
                    n_writes++;
                end
            end
        end
    end

    // Watchdog: ends the run when no handshake of any kind happens for too long.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(negedge clk);
            if (in_accepted + out_taken + cfg_writes != progress_seen) begin
                progress_seen = in_accepted + out_taken + cfg_writes;
                idle_cycles   = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (index)
            CFG_COS_Q:       geo_cos   = data;
            CFG_SIN_Q:       geo_sin   = data;
            CFG_SRC_WIDTH:   geo_src_w = data[10:0];
            CFG_SRC_HEIGHT:  geo_src_h = data[10:0];
            CFG_DEST_WIDTH:  geo_dst_w = data[11:0];
            CFG_DEST_HEIGHT: geo_dst_h = data[11:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every queued item is accepted and every result is back,
    // then lets the pipeline settle so trailing writes are done too.
    task automatic wait_idle;
        while (pending_items.size() != 0 || in_presented != in_accepted ||
               expected_results.size() != 0)
            @(negedge clk);
        repeat (RESULT_LATENCY + 4) @(negedge clk);
    endtask

    // Programs a new geometry on an idle engine and picks the idling style of
    // the phase: both sides random, both flat out, or one side each.
    task automatic start_phase(input logic [15:0] cos_v, input logic [15:0] sin_v,
                               input logic [10:0] sw, input logic [10:0] sh,
                               input logic [11:0] dw, input logic [11:0] dh);
        wait_idle();
        write_register(CFG_COS_Q, cos_v);
        write_register(CFG_SIN_Q, sin_v);
        write_register(CFG_SRC_WIDTH, 16'(sw));
        write_register(CFG_SRC_HEIGHT, 16'(sh));
        write_register(CFG_DEST_WIDTH, 16'(dw));
        write_register(CFG_DEST_HEIGHT, 16'(dh));
        phases_run++;
        in_no_idle  = (phases_run % 4 == 1) || (phases_run % 4 == 3);
        out_no_idle = (phases_run % 4 == 1) || (phases_run % 4 == 2);
    endtask

    // Random traffic under the current geometry: mostly writes inside the
    // source and reads inside (or just past) the destination, with some
    // full-range noise so every coordinate bit toggles.
    task automatic random_phase(input int budget, input bit pause_midway);
        int          count;
        int          pick;
        int          ew;
        int          eh;
        int          dw;
        int          dh;
        logic [10:0] col;
        logic [10:0] row;
        ew    = (geo_src_w < MAX_W) ? int'(geo_src_w) : MAX_W;
        eh    = (geo_src_h < MAX_H) ? int'(geo_src_h) : MAX_H;
        dw    = (geo_dst_w > 2047) ? 2047 : int'(geo_dst_w);
        dh    = (geo_dst_h > 2047) ? 2047 : int'(geo_dst_h);
        count = 0;
        while (count < budget) begin
            // Hold the sender back until the engine has drained completely.
            if (pause_midway && count >= budget / 2) begin
                wait_idle();
                pause_midway = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                count += queue_item(1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)),
                                    11'($urandom_range(0, 2047)), $urandom());
            end else if (pick < 35 && ew > 0 && eh > 0) begin
                count += queue_item(OP_WRITE, 11'($urandom_range(0, ew - 1)),
                                    11'($urandom_range(0, eh - 1)), $urandom());
            end else begin
                col = 11'($urandom_range(0, dw));
                row = 11'($urandom_range(0, dh));
                count += queue_item(OP_READ, col, row, $urandom());
            end
        end
    endtask

    initial begin
        int sent;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset geometry, which is the identity
        // mapping: corners, all-zero and all-one pixels, writes past the
        // source that must be dropped, reads past the destination, a read
        // item carrying a pixel word, and a read right behind a rewrite.
        sent = 0;
        sent += queue_item(OP_WRITE, 11'd0, 11'd0, 32'h0000_0000);
        sent += queue_item(OP_WRITE, 11'd1023, 11'd1023, 32'hFFFF_FFFF);
        sent += queue_item(OP_WRITE, 11'd1023, 11'd0, 32'hA5A5_A5A5);
        sent += queue_item(OP_WRITE, 11'd0, 11'd1023, 32'h5A5A_5A5A);
        sent += queue_item(OP_WRITE, 11'd1024, 11'd0, 32'h1111_1111);
        sent += queue_item(OP_WRITE, 11'd0, 11'd1024, 32'h2222_2222);
        sent += queue_item(OP_WRITE, 11'd2047, 11'd2047, 32'hFFFF_FFFF);
        sent += queue_item(OP_READ, 11'd0, 11'd0, 32'hFFFF_FFFF);
        sent += queue_item(OP_READ, 11'd1023, 11'd1023, 32'h0);
        sent += queue_item(OP_READ, 11'd1023, 11'd0, 32'h0);
        sent += queue_item(OP_READ, 11'd0, 11'd1023, 32'h0);
        sent += queue_item(OP_READ, 11'd1024, 11'd0, 32'h0);
        sent += queue_item(OP_READ, 11'd0, 11'd1024, 32'h0);
        sent += queue_item(OP_READ, 11'd2047, 11'd2047, 32'hFFFF_FFFF);
        sent += queue_item(OP_WRITE, 11'd0, 11'd0, 32'hDEAD_BEEF);
        sent += queue_item(OP_READ, 11'd0, 11'd0, 32'h0);
        sent += queue_item(OP_READ, 11'd1, 11'd1, 32'h0);

        // Quarter turn on a small non-square source.
        start_phase(16'sd0, 16'sd16384, 11'd16, 11'd12, 12'd12, 12'd16);
        random_phase(200, 1'b0);
        // Half turn on a one-pixel source.
        start_phase(-16'sd16384, 16'sd0, 11'd1, 11'd1, 12'd4, 12'd4);
        random_phase(120, 1'b0);
        // Eighth turn; the unimplemented indexes are written as well and
        // the sender pauses for a full drain halfway through.
        start_phase(16'sd11585, 16'sd11585, 11'd32, 11'd24, 12'd40, 12'd40);
        write_register(CFG_SPARE_6, 16'($urandom()));
        write_register(CFG_SPARE_7, 16'hFFFF);
        random_phase(200, 1'b1);
        // Zero source width: nothing can be covered and all writes drop.
        start_phase(16'sd0, 16'sd0, 11'd0, 11'd5, 12'd8, 12'd8);
        random_phase(80, 1'b0);
        // Source registers above the store size: bounds capped, centre not.
        start_phase(16'sd16384, 16'sd0, 11'd2047, 11'd1500, 12'd2048, 12'd2048);
        random_phase(200, 1'b0);
        // Extreme coefficients of the 16-bit fields.
        start_phase(16'sh7FFF, 16'sh8000, 11'd64, 11'd64, 12'd64, 12'd64);
        random_phase(150, 1'b0);
        // Widest destination field with zero height: every read is outside.
        start_phase(-16'sd16384, 16'sd16384, 11'd24, 11'd24, 12'd4095, 12'd0);
        random_phase(60, 1'b0);
        // Random angles on small images.
        repeat (4) begin
            start_phase(16'(int'($urandom_range(0, 32768)) - 16384),
                        16'(int'($urandom_range(0, 32768)) - 16384),
                        11'($urandom_range(1, 64)), 11'($urandom_range(1, 64)),
                        12'($urandom_range(1, 96)), 12'($urandom_range(1, 96)));
            random_phase(180, 1'b0);
        end
        // Random angle at the full source size.
        start_phase(16'(int'($urandom_range(0, 32768)) - 16384),
                    16'(int'($urandom_range(0, 32768)) - 16384),
                    11'd1024, 11'd1024, 12'd1448, 12'd1448);
        random_phase(120, 1'b0);

        wait_idle();
        $display("Run covered %0d writes and %0d reads under %0d programmed geometries;",
                 n_writes, n_reads, phases_run + 1);
        $display("%0d reads landed inside the source, input stalled for %0d cycles.",
                 n_covered, n_backpressure);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/ire_pkg.sv
hw/rtl/image_rotation_engine.sv
tb/tb.sv
